// ----- rtl/core/sha224_pkg.sv -----
// SHA-224 package: round constants, initial hash values, shared types.
// No dependencies.
`default_nettype none
package sha224_pkg;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'hc1059ed8;
      3'd1: r = 32'h367cd507;
      3'd2: r = 32'h3070dd17;
      3'd3: r = 32'hf70e5939;
      3'd4: r = 32'hffc00b31;
      3'd5: r = 32'h68581511;
      3'd6: r = 32'h64f98fa7;
      default: r = 32'hbefa4fa4;
    endcase
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/sha224_queue.sv -----
// Small FIFO between the input front end and the hashing back end.
// Uses sha224_pkg::item_t.
`default_nettype none
module sha224_queue #(
  parameter int unsigned Depth = sha224_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  sha224_pkg::item_t   push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output sha224_pkg::item_t   pop_data_o,
  output logic                empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sha224_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o     = (cnt_q == (AW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sha224_engine.sv -----
// Back end: block assembly, padding, 64-round compression, digest output.
// Uses sha224_pkg.
`default_nettype none
module sha224_engine (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                item_valid_i,
  input  sha224_pkg::item_t  item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_number_o,
  output logic               last_word_o
);
  typedef enum logic [2:0] {
    StIdle, StPadFill, StRound, StAdd, StEmit
  } state_e;

  state_e       state_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   fill_q;
  logic [60:0]  count_q;
  logic [5:0]   round_q;
  logic         fin_q;    // finishing: padding already has its 0x80
  logic         end_q;    // message end pending behind the current block
  logic         lenblk_q; // current block carries the length
  logic [2:0]   wn_q;

  logic [31:0] t1, t2, s0, s1, wnew, wcur, e, a;
  always_comb begin
    e = v_q[4];
    a = v_q[0];
    wcur = w_q[0];
    s0 = sha224_pkg::rotr(w_q[1], 7) ^ sha224_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha224_pkg::rotr(w_q[14], 17) ^ sha224_pkg::rotr(w_q[14], 19)
       ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (sha224_pkg::rotr(e, 6) ^ sha224_pkg::rotr(e, 11)
       ^ sha224_pkg::rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
       + sha224_pkg::RoundK[round_q] + wcur;
    t2 = (sha224_pkg::rotr(a, 2) ^ sha224_pkg::rotr(a, 13) ^ sha224_pkg::rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign item_pop_o    = (state_q == StIdle) && item_valid_i;
  assign out_valid_o   = (state_q == StEmit);
  assign digest_word_o = h_q[wn_q];
  assign word_number_o = wn_q;
  assign last_word_o   = (wn_q == 3'd6);

  // word buffer with one byte written at fill_q: message byte or padding byte
  logic [31:0] wn [16];
  logic        put_en;
  logic [7:0]  put_val;
  always_comb begin
    put_en  = (state_q == StIdle) ? item_i.byte_valid : 1'b1;
    put_val = (state_q == StIdle) ? item_i.data_byte : (fin_q ? 8'h00 : 8'h80);
    for (int i = 0; i < 16; i++) wn[i] = w_q[i];
    if (put_en) begin
      case (fill_q[1:0])
        2'd0: wn[fill_q[5:2]][31:24] = put_val;
        2'd1: wn[fill_q[5:2]][23:16] = put_val;
        2'd2: wn[fill_q[5:2]][15:8] = put_val;
        default: wn[fill_q[5:2]][7:0] = put_val;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 8; i++) h_q[i] <= sha224_pkg::iv_word(3'(i));
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
      fill_q <= '0;
      count_q <= '0;
      round_q <= '0;
      fin_q <= 1'b0;
      end_q <= 1'b0;
      lenblk_q <= 1'b0;
      wn_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            for (int i = 0; i < 16; i++) w_q[i] <= wn[i];
            if (item_i.byte_valid) begin
              count_q <= count_q + 61'd1;
              fill_q <= fill_q + 6'd1;
            end
            if (item_i.byte_valid && fill_q == 6'd63) begin
              fin_q <= 1'b0;
              end_q <= item_i.end_of_message;
              lenblk_q <= 1'b0;
              round_q <= '0;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
              state_q <= StRound;
            end else if (item_i.end_of_message) begin
              fin_q <= 1'b0;
              end_q <= 1'b1;
              state_q <= StPadFill;
            end
          end
        end
        StPadFill: begin
          // fill_q marks the next free byte; places 0x80 unless fin_q shows it is already in, then zeros
          if (fin_q && fill_q == 6'd56) begin
            w_q[14] <= count_q[60:29];
            w_q[15] <= {count_q[28:0], 3'b000};
            lenblk_q <= 1'b1;
            round_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            fill_q <= '0;
            state_q <= StRound;
          end else begin
            for (int i = 0; i < 16; i++) w_q[i] <= wn[i];
            fin_q <= 1'b1;
            lenblk_q <= 1'b0;
            fill_q <= fill_q + 6'd1;
            // no room for the length: compress this block, length goes in the next
            if (fill_q == 6'd63) begin
              round_q <= '0;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnew;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= e;
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= a;
          v_q[0] <= t1 + t2;
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) state_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          fill_q <= '0;
          if (lenblk_q) begin
            wn_q <= '0;
            state_q <= StEmit;
          end else if (end_q) begin
            state_q <= StPadFill;
          end else begin
            state_q <= StIdle;
          end
        end
        StEmit: begin
          if (!out_stall_i) begin
            if (wn_q == 3'd6) begin
              for (int i = 0; i < 8; i++) h_q[i] <= sha224_pkg::iv_word(3'(i));
              count_q <= '0;
              fin_q <= 1'b0;
              end_q <= 1'b0;
              lenblk_q <= 1'b0;
              wn_q <= '0;
              state_q <= StIdle;
            end else begin
              wn_q <= wn_q + 3'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sha224_message_hasher.sv -----
// SHA-224 message hasher top level: input queue plus hashing engine.
// Depends on sha224_pkg, sha224_queue, sha224_engine.
//
// Byte items enter a small queue and are taken by the engine one per cycle
// while a block fills. A full block is compressed in the single shared
// round unit (one round per cycle, plus load and feed-forward). Ending a
// message takes padding, one or two compressions, and seven output beats,
// one per cycle unless stalled.
`default_nettype none
module sha224_message_hasher #(
  parameter int unsigned QueueDepth = sha224_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         byte_valid_i,
  input  wire         end_of_message_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);
  sha224_pkg::item_t in_item, q_item;
  logic full, empty, pop;

  assign in_item = '{data_byte: data_byte_i, byte_valid: byte_valid_i,
                     end_of_message: end_of_message_i};
  assign in_stall_o = full;

  sha224_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && !full), .push_data_i(in_item), .full_o(full),
    .pop_i(pop), .pop_data_o(q_item), .empty_o(empty)
  );

  sha224_engine u_engine (
    .clk_i, .rst_ni,
    .item_valid_i(!empty), .item_i(q_item), .item_pop_o(pop),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_number_o, .last_word_o
  );
endmodule
`default_nettype wire
